// ===== hw/rtl/lcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpt_pkg
// shared types, link constants and rounding helper for the leg torque unit
// ----------------------------------------------------------------------------
package lcpt_pkg;

    typedef logic signed [15:0] s16_t;

    typedef struct packed {
        logic [2:0][15:0] rate;
        logic [2:0][15:0] tp;
        logic [2:0][15:0] tv;
    } aux_t;

    localparam logic signed [15:0] ABAD_LINK        = 16'sd1311;
    localparam logic signed [15:0] HIP_LINK         = 16'sd3277;
    localparam logic signed [15:0] KNEE_LINK        = 16'sd3277;
    localparam logic signed [15:0] BODY_HALF_LENGTH = 16'sd3087;
    localparam logic signed [15:0] BODY_HALF_WIDTH  = 16'sd768;

    localparam logic [2:0] REG_LEG_INDEX = 3'd0;
    localparam logic [2:0] REG_FRAME     = 3'd1;
    localparam logic [2:0] REG_KP_ROW0   = 3'd2;
    localparam logic [2:0] REG_KP_ROW1   = 3'd3;
    localparam logic [2:0] REG_KP_ROW2   = 3'd4;
    localparam logic [2:0] REG_KD_ROW0   = 3'd5;
    localparam logic [2:0] REG_KD_ROW1   = 3'd6;
    localparam logic [2:0] REG_KD_ROW2   = 3'd7;

    // round half up then arithmetic shift
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
        logic signed [63:0] w;
        begin
            w = v + (64'sd1 <<< (n - 1));
            return w >>> n;
        end
    endfunction

endpackage

// ===== hw/rtl/lcpt_trig.sv =====
// ----------------------------------------------------------------------------
// lcpt_trig
// five stage sine and cosine of the three joint angles
// ----------------------------------------------------------------------------
module lcpt_trig (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lcpt_pkg::s16_t     angle [3],
    input  lcpt_pkg::aux_t     aux_in,
    output logic               out_valid,
    input  logic               out_ready,
    output lcpt_pkg::s16_t     sn [3],
    output lcpt_pkg::s16_t     cs [3],
    output lcpt_pkg::aux_t     aux_out
);
    import lcpt_pkg::*;

    localparam int NS = 5;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   en;

    logic [15:0]        p_reg   [3];
    logic [14:0]        x_reg   [3:1][6];
    logic [14:0]        x2_reg  [3:2][6];
    logic               neg_reg [3:1][6];
    logic [13:0]        ta_reg  [6];
    logic [14:0]        tb_reg  [6];
    s16_t               s_reg   [6];
    aux_t               aux_reg [NS];

    logic [15:0]        p_next  [3];
    logic [14:0]        x_next  [6];
    logic [14:0]        x2_next [6];
    logic               neg_next [6];
    logic [13:0]        ta_next [6];
    logic [14:0]        tb_next [6];
    s16_t               s_next  [6];

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    always_comb
    begin
        logic signed [35:0] m1;
        logic [15:0]        ph;
        logic [29:0]        sq;
        logic [24:0]        m3;
        logic [28:0]        m4;
        logic [29:0]        m5;
        int                 idx;
        for (int j = 0; j < 3; j++)
        begin
            m1 = 36'(angle[j]) * 36'sd166886 + 36'sd32768;
            p_next[j] = m1[31:16];
        end
        for (int k = 0; k < 6; k++)
        begin
            idx = (k >= 3) ? k - 3 : k;
            ph = (k >= 3) ? p_reg[idx] + 16'd16384 : p_reg[idx];
            neg_next[k] = ph[15];
            x_next[k] = ph[14] ? 15'(15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
            sq = 30'(x_next[k]) * 30'(x_next[k]);
            x2_next[k] = sq[28:14];
            m3 = 25'(x2_reg[2][k]) * 25'd1160;
            ta_next[k] = 14'd10512 - {3'b0, m3[24:14]};
            m4 = 29'(ta_reg[k]) * 29'(x2_reg[3][k]);
            tb_next[k] = 15'd25736 - {1'b0, m4[27:14]};
            m5 = 30'(tb_reg[k]) * 30'(x_reg[3][k]);
            s_next[k] = neg_reg[3][k] ? -signed'(m5[29:14]) : signed'(m5[29:14]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_reg      <= p_next;
            aux_reg[0] <= aux_in;
        end
        if (en[1])
        begin
            x_reg[1]   <= x_next;
            x2_reg[2]  <= x2_next;
            neg_reg[1] <= neg_next;
            aux_reg[1] <= aux_reg[0];
        end
        if (en[2])
        begin
            ta_reg      <= ta_next;
            x_reg[2]    <= x_reg[1];
            x2_reg[3]   <= x2_reg[2];
            neg_reg[2]  <= neg_reg[1];
            aux_reg[2]  <= aux_reg[1];
        end
        if (en[3])
        begin
            tb_reg      <= tb_next;
            x_reg[3]    <= x_reg[2];
            neg_reg[3]  <= neg_reg[2];
            aux_reg[3]  <= aux_reg[2];
        end
        if (en[4])
        begin
            s_reg       <= s_next;
            aux_reg[4]  <= aux_reg[3];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sn[j] = s_reg[j];
            cs[j] = s_reg[j+3];
        end
    end

    assign aux_out = aux_reg[NS-1];

endmodule

// ===== hw/rtl/lcpt_kin.sv =====
// ----------------------------------------------------------------------------
// lcpt_kin
// five stage leg jacobian, foot position, velocity and cartesian errors
// ----------------------------------------------------------------------------
module lcpt_kin (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         leg_index,
    input  logic               frame_select,
    input  logic               in_valid,
    output logic               in_ready,
    input  lcpt_pkg::s16_t     sn [3],
    input  lcpt_pkg::s16_t     cs [3],
    input  lcpt_pkg::aux_t     aux_in,
    output logic               out_valid,
    input  logic               out_ready,
    output lcpt_pkg::s16_t     jac [3][3],
    output logic signed [16:0] ep [3],
    output logic signed [22:0] ev [3]
);
    import lcpt_pkg::*;

    localparam int NS = 5;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   en;

    // stage 1
    logic signed [17:0] c23_reg, s23_reg, s1c2_reg, c1c2_reg, s1s2_reg, c1s2_reg;
    s16_t               sn0_reg, cs0_reg, sn1_reg, cs1_reg;
    aux_t               aux1_reg, aux2_reg, aux3_reg;
    // stage 2
    logic signed [17:0] s1c23_reg, c1c23_reg, s1s23_reg, c1s23_reg;
    logic signed [17:0] c23b_reg, s23b_reg, s1c2b_reg, c1c2b_reg, s1s2b_reg, c1s2b_reg;
    s16_t               sn0b_reg, cs0b_reg, sn1b_reg, cs1b_reg;
    // stage 3
    s16_t               jac3_reg [3][3];
    s16_t               pos_reg  [3];
    // stage 4
    s16_t               jac4_reg [3][3];
    logic signed [21:0] vel_reg  [3];
    logic signed [16:0] ep4_reg  [3];
    logic [2:0][15:0]   tv4_reg;
    // stage 5
    s16_t               jac5_reg [3][3];
    logic signed [16:0] ep5_reg  [3];
    logic signed [22:0] ev_reg   [3];

    logic signed [17:0] c23_next, s23_next, s1c2_next, c1c2_next, s1s2_next, c1s2_next;
    logic signed [17:0] s1c23_next, c1c23_next, s1s23_next, c1s23_next;
    s16_t               jac_next [3][3];
    s16_t               pos_next [3];
    logic signed [21:0] vel_next [3];
    logic signed [16:0] ep_next  [3];
    logic signed [22:0] ev_next  [3];

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    // trig products
    always_comb
    begin
        c23_next  = 18'(rnd(64'(34'(cs[1]) * 34'(cs[2])) - 64'(34'(sn[1]) * 34'(sn[2])), 14));
        s23_next  = 18'(rnd(64'(34'(sn[1]) * 34'(cs[2])) + 64'(34'(cs[1]) * 34'(sn[2])), 14));
        s1c2_next = 18'(rnd(64'(34'(sn[0]) * 34'(cs[1])), 14));
        c1c2_next = 18'(rnd(64'(34'(cs[0]) * 34'(cs[1])), 14));
        s1s2_next = 18'(rnd(64'(34'(sn[0]) * 34'(sn[1])), 14));
        c1s2_next = 18'(rnd(64'(34'(cs[0]) * 34'(sn[1])), 14));
        s1c23_next = 18'(rnd(64'(36'(sn0_reg) * 36'(c23_reg)), 14));
        c1c23_next = 18'(rnd(64'(36'(cs0_reg) * 36'(c23_reg)), 14));
        s1s23_next = 18'(rnd(64'(36'(sn0_reg) * 36'(s23_reg)), 14));
        c1s23_next = 18'(rnd(64'(36'(cs0_reg) * 36'(s23_reg)), 14));
    end

    // link sums, position and jacobian
    always_comb
    begin
        logic signed [63:0] l1, l2, l3, len, wid;
        l1 = (leg_index == 2'd0 || leg_index == 2'd2) ? -64'(ABAD_LINK) : 64'(ABAD_LINK);
        l2 = -64'(HIP_LINK);
        l3 = -64'(KNEE_LINK);
        wid = (leg_index == 2'd0 || leg_index == 2'd2) ? -64'(BODY_HALF_WIDTH)
                                                       : 64'(BODY_HALF_WIDTH);
        len = (leg_index == 2'd2 || leg_index == 2'd3) ? -64'(BODY_HALF_LENGTH)
                                                       : 64'(BODY_HALF_LENGTH);
        pos_next[0] = 16'(rnd(l3 * 64'(s23b_reg) + l2 * 64'(sn1b_reg), 14)
                          + (frame_select ? len : 64'sd0));
        pos_next[1] = 16'(rnd(-l3 * 64'(s1c23_reg) + l1 * 64'(cs0b_reg)
                              - l2 * 64'(s1c2b_reg), 14)
                          + (frame_select ? wid : 64'sd0));
        pos_next[2] = 16'(rnd(l3 * 64'(c1c23_reg) + l1 * 64'(sn0b_reg)
                              + l2 * 64'(c1c2b_reg), 14));
        jac_next[0][0] = '0;
        jac_next[1][0] = 16'(rnd(-l3 * 64'(c1c23_reg) - l2 * 64'(c1c2b_reg)
                                 - l1 * 64'(sn0b_reg), 14));
        jac_next[2][0] = 16'(rnd(-l3 * 64'(s1c23_reg) - l2 * 64'(s1c2b_reg)
                                 + l1 * 64'(cs0b_reg), 14));
        jac_next[0][1] = 16'(rnd(l3 * 64'(c23b_reg) + l2 * 64'(cs1b_reg), 14));
        jac_next[1][1] = 16'(rnd(l3 * 64'(s1s23_reg) + l2 * 64'(s1s2b_reg), 14));
        jac_next[2][1] = 16'(rnd(-l3 * 64'(c1s23_reg) - l2 * 64'(c1s2b_reg), 14));
        jac_next[0][2] = 16'(rnd(l3 * 64'(c23b_reg), 14));
        jac_next[1][2] = 16'(rnd(l3 * 64'(s1s23_reg), 14));
        jac_next[2][2] = 16'(rnd(-l3 * 64'(c1s23_reg), 14));
    end

    // velocity and errors
    always_comb
    begin
        logic signed [33:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            acc = '0;
            for (int j = 0; j < 3; j++)
            begin
                acc = acc + 34'(32'(jac3_reg[i][j]) * 32'(signed'(aux3_reg.rate[j])));
            end
            vel_next[i] = 22'(rnd(64'(acc), 12));
            ep_next[i]  = 17'(signed'(aux3_reg.tp[i])) - 17'(pos_reg[i]);
            ev_next[i]  = 23'(signed'(tv4_reg[i])) - 23'(vel_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c23_reg  <= c23_next;
            s23_reg  <= s23_next;
            s1c2_reg <= s1c2_next;
            c1c2_reg <= c1c2_next;
            s1s2_reg <= s1s2_next;
            c1s2_reg <= c1s2_next;
            sn0_reg  <= sn[0];
            cs0_reg  <= cs[0];
            sn1_reg  <= sn[1];
            cs1_reg  <= cs[1];
            aux1_reg <= aux_in;
        end
        if (en[1])
        begin
            s1c23_reg <= s1c23_next;
            c1c23_reg <= c1c23_next;
            s1s23_reg <= s1s23_next;
            c1s23_reg <= c1s23_next;
            c23b_reg  <= c23_reg;
            s23b_reg  <= s23_reg;
            s1c2b_reg <= s1c2_reg;
            c1c2b_reg <= c1c2_reg;
            s1s2b_reg <= s1s2_reg;
            c1s2b_reg <= c1s2_reg;
            sn0b_reg  <= sn0_reg;
            cs0b_reg  <= cs0_reg;
            sn1b_reg  <= sn1_reg;
            cs1b_reg  <= cs1_reg;
            aux2_reg  <= aux1_reg;
        end
        if (en[2])
        begin
            jac3_reg <= jac_next;
            pos_reg  <= pos_next;
            aux3_reg <= aux2_reg;
        end
        if (en[3])
        begin
            jac4_reg <= jac3_reg;
            vel_reg  <= vel_next;
            ep4_reg  <= ep_next;
            tv4_reg  <= aux3_reg.tv;
        end
        if (en[4])
        begin
            jac5_reg <= jac4_reg;
            ep5_reg  <= ep4_reg;
            ev_reg   <= ev_next;
        end
    end

    assign jac = jac5_reg;
    assign ep  = ep5_reg;
    assign ev  = ev_reg;

endmodule

// ===== hw/rtl/lcpt_force.sv =====
// ----------------------------------------------------------------------------
// lcpt_force
// four stage gain matrices, jacobian transpose and torque saturation
// ----------------------------------------------------------------------------
module lcpt_force (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [47:0]        kp_row [3],
    input  logic [47:0]        kd_row [3],
    input  logic               in_valid,
    output logic               in_ready,
    input  lcpt_pkg::s16_t     jac [3][3],
    input  logic signed [16:0] ep [3],
    input  logic signed [22:0] ev [3],
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] torque [3]
);
    import lcpt_pkg::*;

    localparam int NS = 4;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   en;

    logic signed [41:0] f_reg    [3];
    s16_t               jac_reg  [3][3];
    logic signed [38:0] hi_reg   [3];
    logic signed [39:0] lo_reg   [3];
    logic signed [43:0] t_reg    [3];
    logic signed [31:0] tq_reg   [3];

    logic signed [41:0] f_next   [3];
    logic signed [38:0] hi_next  [3];
    logic signed [39:0] lo_next  [3];
    logic signed [43:0] t_next   [3];
    logic signed [31:0] tq_next  [3];

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    always_comb
    begin
        logic signed [34:0] a;
        logic signed [40:0] b;
        logic signed [20:0] fh;
        logic signed [21:0] fl;
        logic signed [63:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            a = '0;
            b = '0;
            for (int j = 0; j < 3; j++)
            begin
                a = a + 35'(33'(signed'(kp_row[i][16*j +: 16])) * 33'(ep[j]));
                b = b + 41'(39'(signed'(kd_row[i][16*j +: 16])) * 39'(ev[j]));
            end
            f_next[i] = 42'(a) * 42'sd4 + 42'(b);
        end
        // split force into upper and lower partial products
        for (int j = 0; j < 3; j++)
        begin
            hi_next[j] = '0;
            lo_next[j] = '0;
            for (int i = 0; i < 3; i++)
            begin
                fh = f_reg[i][41:21];
                fl = signed'({1'b0, f_reg[i][20:0]});
                hi_next[j] = hi_next[j] + 39'(37'(jac_reg[i][j]) * 37'(fh));
                lo_next[j] = lo_next[j] + 40'(38'(jac_reg[i][j]) * 38'(fl));
            end
            acc = (64'(hi_reg[j]) <<< 21) + 64'(lo_reg[j]);
            t_next[j] = 44'(rnd(acc, 18));
            if (t_reg[j] > 44'sd2147483647)
            begin
                tq_next[j] = 32'sh7fffffff;
            end
            else if (t_reg[j] < -44'sd2147483648)
            begin
                tq_next[j] = 32'sh80000000;
            end
            else
            begin
                tq_next[j] = t_reg[j][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            f_reg   <= f_next;
            jac_reg <= jac;
        end
        if (en[1])
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
        if (en[2])
        begin
            t_reg <= t_next;
        end
        if (en[3])
        begin
            tq_reg <= tq_next;
        end
    end

    assign torque = tq_reg;

endmodule

// ===== hw/rtl/leg_cartesian_pd_torque_unit.sv =====
// ----------------------------------------------------------------------------
// leg_cartesian_pd_torque_unit
// stages: 5 trig, 5 kinematics, 4 force and torque; throughput: one item per
// cycle while the output is not stalled, every stage
// register has its own valid bit and holds under back pressure
// reset: asynchronous active low, clears all valid bits and config registers
// ----------------------------------------------------------------------------
module leg_cartesian_pd_torque_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // abad_angle, hip_angle, knee_angle, abad_rate, hip_rate, knee_rate,
    // target_x, target_y, target_z, target_vx, target_vy, target_vz
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // torque_abad, torque_hip, torque_knee
    output logic [95:0]  m_tdata
);
    import lcpt_pkg::*;

    logic [1:0]  leg_index_reg;
    logic        frame_reg;
    logic [47:0] kp_reg [3];
    logic [47:0] kd_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leg_index_reg <= '0;
            frame_reg     <= 1'b0;
            kp_reg        <= '{default: '0};
            kd_reg        <= '{default: '0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEG_INDEX: leg_index_reg <= cfg_data[1:0];
                REG_FRAME:     frame_reg     <= cfg_data[0];
                REG_KP_ROW0:   kp_reg[0]     <= cfg_data;
                REG_KP_ROW1:   kp_reg[1]     <= cfg_data;
                REG_KP_ROW2:   kp_reg[2]     <= cfg_data;
                REG_KD_ROW0:   kd_reg[0]     <= cfg_data;
                REG_KD_ROW1:   kd_reg[1]     <= cfg_data;
                REG_KD_ROW2:   kd_reg[2]     <= cfg_data;
                default:       leg_index_reg <= leg_index_reg;
            endcase
        end
    end

    s16_t angle [3];
    aux_t aux_in;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            angle[j]       = s_tdata[16*j +: 16];
            aux_in.rate[j] = s_tdata[48 + 16*j +: 16];
            aux_in.tp[j]   = s_tdata[96 + 16*j +: 16];
            aux_in.tv[j]   = s_tdata[144 + 16*j +: 16];
        end
    end

    logic               trig_valid, trig_ready;
    s16_t               sn [3];
    s16_t               cs [3];
    aux_t               aux_trig;
    logic               kin_valid, kin_ready;
    s16_t               jac [3][3];
    logic signed [16:0] ep [3];
    logic signed [22:0] ev [3];
    logic signed [31:0] torque [3];

    lcpt_trig u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .angle     (angle),
        .aux_in    (aux_in),
        .out_valid (trig_valid),
        .out_ready (trig_ready),
        .sn        (sn),
        .cs        (cs),
        .aux_out   (aux_trig)
    );

    lcpt_kin u_kin (
        .clk          (clk),
        .rst_n        (rst_n),
        .leg_index    (leg_index_reg),
        .frame_select (frame_reg),
        .in_valid     (trig_valid),
        .in_ready     (trig_ready),
        .sn           (sn),
        .cs           (cs),
        .aux_in       (aux_trig),
        .out_valid    (kin_valid),
        .out_ready    (kin_ready),
        .jac          (jac),
        .ep           (ep),
        .ev           (ev)
    );

    lcpt_force u_force (
        .clk       (clk),
        .rst_n     (rst_n),
        .kp_row    (kp_reg),
        .kd_row    (kd_reg),
        .in_valid  (kin_valid),
        .in_ready  (kin_ready),
        .jac       (jac),
        .ep        (ep),
        .ev        (ev),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .torque    (torque)
    );

    assign m_tdata = {torque[2], torque[1], torque[0]};

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the leg cartesian pd torque unit: streams joint
// states and foot targets under random idling and back pressure, predicts
// the saturated jacobian-transpose torques at input accept and checks every
// output item in order, over several leg, frame and gain settings
// ----------------------------------------------------------------------------
module tb_top;
    import lcpt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [47:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;

    logic [191:0] pending_items[$];
    logic [95:0]  torque_expect[$];
    logic [1:0]   leg_sel = '0;
    logic         body_frame = 1'b0;
    logic [47:0]  kp_row[3] = '{default: '0};
    logic [47:0]  kd_row[3] = '{default: '0};
    int           cycle_cnt = 0;
    int           err_cnt = 0;
    int           hold_req = 0;
    int           hold_ack = 0;
    int           hold_left = 0;

    leg_cartesian_pd_torque_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit roll_idle();
        if (cycle_cnt > 5000 && cycle_cnt < 9000)
            return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    function automatic longint shift_round(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint quarter_wave(input logic [31:0] x);
        logic [31:0] x2, t;
        x2 = (x * x) >> 14;
        t = (32'd1160 * x2) >> 14;
        t = 32'd10512 - t;
        t = (t * x2) >> 14;
        t = 32'd25736 - t;
        return longint'((t * x) >> 14);
    endfunction

    function automatic longint phase_sin(input logic [15:0] p);
        longint s;
        s = p[14] ? quarter_wave(32'd16384 - 32'(p[13:0])) : quarter_wave(32'(p[13:0]));
        return p[15] ? -s : s;
    endfunction

    function automatic logic [15:0] angle_phase(input longint a);
        logic [63:0] v;
        v = a * 64'd166886 + 64'd32768;
        return v[31:16];
    endfunction

    function automatic logic [95:0] predict_torque(input logic [191:0] item);
        longint sn[3], cs[3], rate[3], tp[3], tv[3], pos[3], vel[3], ep[3], ev[3];
        longint f[3], jac[3][3];
        longint l1, l2, l3, c23, s23, s1c23, c1c23, s1c2, c1c2, s1s23, s1s2;
        longint c1s23, c1s2, acc, a, b, t;
        logic [15:0] p;
        logic [95:0] res;
        for (int i = 0; i < 3; i++)
        begin
            p = angle_phase(longint'($signed(item[16*i +: 16])));
            sn[i] = phase_sin(p);
            cs[i] = phase_sin(p + 16'd16384);
            rate[i] = longint'($signed(item[16*(3+i) +: 16]));
            tp[i] = longint'($signed(item[16*(6+i) +: 16]));
            tv[i] = longint'($signed(item[16*(9+i) +: 16]));
        end
        l1 = (leg_sel == 2'd0 || leg_sel == 2'd2) ? -longint'(ABAD_LINK)
                                                  : longint'(ABAD_LINK);
        l2 = -longint'(HIP_LINK);
        l3 = -longint'(KNEE_LINK);
        c23 = shift_round(cs[1] * cs[2] - sn[1] * sn[2], 14);
        s23 = shift_round(sn[1] * cs[2] + cs[1] * sn[2], 14);
        s1c23 = shift_round(sn[0] * c23, 14);
        c1c23 = shift_round(cs[0] * c23, 14);
        s1c2 = shift_round(sn[0] * cs[1], 14);
        c1c2 = shift_round(cs[0] * cs[1], 14);
        s1s23 = shift_round(sn[0] * s23, 14);
        s1s2 = shift_round(sn[0] * sn[1], 14);
        c1s23 = shift_round(cs[0] * s23, 14);
        c1s2 = shift_round(cs[0] * sn[1], 14);
        pos[0] = shift_round(l3 * s23 + l2 * sn[1], 14);
        pos[1] = shift_round(-l3 * s1c23 + l1 * cs[0] - l2 * s1c2, 14);
        pos[2] = shift_round(l3 * c1c23 + l1 * sn[0] + l2 * c1c2, 14);
        if (body_frame)
        begin
            pos[0] += (leg_sel >= 2'd2) ? -longint'(BODY_HALF_LENGTH)
                                        : longint'(BODY_HALF_LENGTH);
            pos[1] += (leg_sel == 2'd0 || leg_sel == 2'd2) ? -longint'(BODY_HALF_WIDTH)
                                                           : longint'(BODY_HALF_WIDTH);
        end
        jac[0][0] = 0;
        jac[1][0] = shift_round(-l3 * c1c23 - l2 * c1c2 - l1 * sn[0], 14);
        jac[2][0] = shift_round(-l3 * s1c23 - l2 * s1c2 + l1 * cs[0], 14);
        jac[0][1] = shift_round(l3 * c23 + l2 * cs[1], 14);
        jac[1][1] = shift_round(l3 * s1s23 + l2 * s1s2, 14);
        jac[2][1] = shift_round(-l3 * c1s23 - l2 * c1s2, 14);
        jac[0][2] = shift_round(l3 * c23, 14);
        jac[1][2] = shift_round(l3 * s1s23, 14);
        jac[2][2] = shift_round(-l3 * c1s23, 14);
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += jac[i][j] * rate[j];
            vel[i] = shift_round(acc, 12);
            ep[i] = tp[i] - pos[i];
            ev[i] = tv[i] - vel[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            a = 0;
            b = 0;
            for (int j = 0; j < 3; j++)
            begin
                a += longint'($signed(kp_row[i][16*j +: 16])) * ep[j];
                b += longint'($signed(kd_row[i][16*j +: 16])) * ev[j];
            end
            f[i] = 4 * a + b;
        end
        for (int j = 0; j < 3; j++)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += jac[i][j] * f[i];
            t = shift_round(acc, 18);
            if (t > 64'sd2147483647)
                t = 64'sd2147483647;
            if (t < -64'sd2147483648)
                t = -64'sd2147483648;
            res[32*j +: 32] = t[31:0];
        end
        return res;
    endfunction

    // sender: predicts at accept, then offers the next item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                torque_expect.push_back(predict_torque(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 && !roll_idle())
                begin
                    s_tdata <= pending_items.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each output item, random stalls and one long hold
    always @(posedge clk)
    begin
        logic [95:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (torque_expect.size() == 0)
                begin
                    $error("unexpected output item %h", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = torque_expect.pop_front();
                    if (m_tdata[31:0] !== want[31:0])
                    begin
                        $error("torque_abad expected %0d got %0d",
                               $signed(want[31:0]), $signed(m_tdata[31:0]));
                        err_cnt++;
                    end
                    if (m_tdata[63:32] !== want[63:32])
                    begin
                        $error("torque_hip expected %0d got %0d",
                               $signed(want[63:32]), $signed(m_tdata[63:32]));
                        err_cnt++;
                    end
                    if (m_tdata[95:64] !== want[95:64])
                    begin
                        $error("torque_knee expected %0d got %0d",
                               $signed(want[95:64]), $signed(m_tdata[95:64]));
                        err_cnt++;
                    end
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack <= hold_req;
                hold_left <= 300;
                m_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !roll_idle();
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LEG_INDEX: leg_sel = val[1:0];
            REG_FRAME:     body_frame = val[0];
            REG_KP_ROW0:   kp_row[0] = val;
            REG_KP_ROW1:   kp_row[1] = val;
            REG_KP_ROW2:   kp_row[2] = val;
            REG_KD_ROW0:   kd_row[0] = val;
            REG_KD_ROW1:   kd_row[1] = val;
            default:       kd_row[2] = val;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || torque_expect.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [191:0] pack_item(input logic [15:0] ang[3],
                                               input logic [15:0] rt[3],
                                               input logic [15:0] tpos[3],
                                               input logic [15:0] tvel[3]);
        logic [191:0] d;
        for (int i = 0; i < 3; i++)
        begin
            d[16*i +: 16] = ang[i];
            d[16*(3+i) +: 16] = rt[i];
            d[16*(6+i) +: 16] = tpos[i];
            d[16*(9+i) +: 16] = tvel[i];
        end
        return d;
    endfunction

    function automatic logic [15:0] rand_field(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 12868) - 6434);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    function automatic logic [47:0] rand_gains(input int mode);
        logic [47:0] g;
        for (int c = 0; c < 3; c++)
            g[16*c +: 16] = rand_field(mode == 0 ? 0 : (mode == 1 ? 2 : 3));
        return g;
    endfunction

    initial
    begin
        logic [15:0] ang[3], rt[3], tpos[3], tvel[3];
        logic [47:0] gsets[6][6];
        logic [1:0]  legs[6];
        logic        frames[6];
        int          gmode;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        legs = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3};
        frames = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            // leg register also gets junk upper bits
            write_reg(REG_LEG_INDEX, {46'($urandom), legs[ph]});
            write_reg(REG_FRAME, {47'($urandom), frames[ph]});
            for (int r = 0; r < 6; r++)
            begin
                case (ph)
                    0:       gsets[ph][r] = '0;
                    1:       gsets[ph][r] = {3{16'h7FFF}};
                    2:       gsets[ph][r] = {3{16'h8000}};
                    3:       gsets[ph][r] = rand_gains(2);
                    default: gsets[ph][r] = rand_gains(ph == 4 ? 0 : 1);
                endcase
                write_reg(3'(REG_KP_ROW0 + r), gsets[ph][r]);
            end

            if (ph == 0 || ph == 1)
            begin
                // field extremes, zero pose, wrapped angles, saturation push
                for (int k = 0; k < 12; k++)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        case (k % 4)
                            0: begin ang[i] = 16'h0000; rt[i] = 16'h0000; end
                            1: begin ang[i] = 16'h7FFF; rt[i] = 16'h7FFF; end
                            2: begin ang[i] = 16'h8000; rt[i] = 16'h8000; end
                            default: begin ang[i] = rand_field(2); rt[i] = rand_field(2); end
                        endcase
                        tpos[i] = (k < 4) ? rt[i] : rand_field(2);
                        tvel[i] = (k < 4) ? ~rt[i] : rand_field(2);
                    end
                    if (k >= 8)
                        ang[k - 8] = 16'(13000 + 100 * k);
                    pending_items.push_back(pack_item(ang, rt, tpos, tvel));
                end
            end

            for (int n = 0; n < 280; n++)
            begin
                gmode = $urandom_range(0, 9);
                for (int i = 0; i < 3; i++)
                begin
                    ang[i] = rand_field(gmode < 4 ? 0 : (gmode < 8 ? 1 : 2));
                    rt[i] = rand_field(gmode < 6 ? 0 : (gmode < 9 ? 3 : 2));
                    tpos[i] = rand_field(gmode < 5 ? 0 : (gmode < 9 ? 3 : 2));
                    tvel[i] = rand_field(gmode < 5 ? 0 : (gmode < 9 ? 3 : 2));
                end
                pending_items.push_back(pack_item(ang, rt, tpos, tvel));
            end
            if (ph == 2)
                hold_req = hold_req + 1;
        end

        wait_drained();
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lcpt_pkg.sv
hw/rtl/lcpt_trig.sv
hw/rtl/lcpt_kin.sv
hw/rtl/lcpt_force.sv
hw/rtl/leg_cartesian_pd_torque_unit.sv
tb/sv/tb_top.sv
